// ===== design/ubx_ff_pkg.sv =====
// Shared types and constants for the binary frame filter.
package ubx_ff_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_CLASS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_ID    = 1'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_offset;
    logic        frame_status;
    logic        last;
  } result_t;

endpackage

// ===== design/ubx_ff_parser.sv =====
// Frame parser: sync search, header capture, Fletcher check and match filter.
module ubx_ff_parser import ubx_ff_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  output logic                 res_valid,
  output result_t              res
);

  logic [7:0]  wanted_class;
  logic [7:0]  wanted_id;
  phase_t      phase, phase_next;
  logic [7:0]  frame_class;
  logic [15:0] payload_length;
  logic [15:0] bytes_seen;
  logic [7:0]  sum_a, sum_b;
  logic [7:0]  sum_a_acc, sum_b_acc;
  logic [7:0]  first_check_byte;
  logic        frame_matches;
  logic [15:0] seen_inc;
  logic [15:0] len_full;

  assign sum_a_acc = sum_a + in_byte;
  assign sum_b_acc = sum_b + sum_a_acc;
  assign seen_inc  = bytes_seen + 16'd1;
  assign len_full  = {in_byte, payload_length[7:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_class <= '0;
      wanted_id    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WANTED_CLASS: wanted_class <= cfg_data;
        REG_WANTED_ID:    wanted_id    <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    phase_next = PH_SYNC1;
    unique case (phase)
      PH_SYNC2: begin
        if (in_byte == SYNC_SECOND) phase_next = PH_CLASS;
        else if (in_byte == SYNC_FIRST) phase_next = PH_SYNC2;
        else phase_next = PH_SYNC1;
      end
      PH_CLASS:   phase_next = PH_ID;
      PH_ID:      phase_next = PH_LEN_LO;
      PH_LEN_LO:  phase_next = PH_LEN_HI;
      PH_LEN_HI:  phase_next = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      PH_PAYLOAD: phase_next = (seen_inc == payload_length) ? PH_CK_A : PH_PAYLOAD;
      PH_CK_A:    phase_next = PH_CK_B;
      PH_CK_B:    phase_next = PH_SYNC1;
      default:    phase_next = (in_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SYNC1;
      frame_class      <= '0;
      payload_length   <= '0;
      bytes_seen       <= '0;
      sum_a            <= '0;
      sum_b            <= '0;
      first_check_byte <= '0;
      frame_matches    <= 1'b0;
    end else if (in_fire) begin
      phase <= phase_next;
      case (phase)
        PH_SYNC2: begin
          if (in_byte == SYNC_SECOND) begin
            sum_a <= '0;
            sum_b <= '0;
          end
        end
        PH_CLASS: begin
          frame_class <= in_byte;
          sum_a <= sum_a_acc;
          sum_b <= sum_b_acc;
        end
        PH_ID: begin
          frame_matches <= (frame_class == wanted_class) && (in_byte == wanted_id);
          sum_a <= sum_a_acc;
          sum_b <= sum_b_acc;
        end
        PH_LEN_LO: begin
          payload_length <= {8'd0, in_byte};
          sum_a <= sum_a_acc;
          sum_b <= sum_b_acc;
        end
        PH_LEN_HI: begin
          payload_length <= len_full;
          bytes_seen     <= '0;
          sum_a <= sum_a_acc;
          sum_b <= sum_b_acc;
        end
        PH_PAYLOAD: begin
          bytes_seen <= seen_inc;
          sum_a <= sum_a_acc;
          sum_b <= sum_b_acc;
        end
        PH_CK_A: first_check_byte <= in_byte;
        PH_CK_B: frame_matches <= 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (phase == PH_PAYLOAD && frame_matches) begin
      res_valid        = 1'b1;
      res.item_kind    = KIND_PAYLOAD;
      res.payload_byte = in_byte;
      res.byte_offset  = bytes_seen;
    end else if (phase == PH_CK_B && frame_matches) begin
      res_valid        = 1'b1;
      res.item_kind    = KIND_END;
      res.byte_offset  = payload_length;
      res.frame_status = (first_check_byte != sum_a) || (in_byte != sum_b);
      res.last         = 1'b1;
    end
  end

endmodule

// ===== design/ubx_frame_filter_top.sv =====
// Top level of the binary frame filter: parser plus output register and skid stage.
//
//  channel | dir | tdata                                   | tuser     | tlast
//  s_axis  | in  | [7:0] data_byte                         | -         | -
//  m_axis  | out | [7:0] payload_byte [23:8] byte_offset   | item_kind | last
//          |     | [24] frame_status [31:25] zero          |           |
//  cfg     | in  | cfg_we, cfg_index, cfg_data             |           |
//
// One byte per cycle while s_tready is high; each byte is parsed in the cycle it is taken
// and its result is registered in the output register, or in the skid entry on a stall.
// An output register plus one skid entry let input run on while m_tready is
// low until a second result is waiting; s_tready is low while the skid entry is full.
// Synchronous reset returns the parser to sync search and empties the output.
module ubx_frame_filter_top import ubx_ff_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // [7:0] payload_byte, [23:8] byte_offset, [24] frame_status
  output logic                 m_tuser,   // [0] item_kind
  output logic                 m_tlast
);

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;
  logic    out_free;

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  ubx_ff_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (in_fire && res_valid) begin
      skid_reg <= res;
    end
  end

  assign m_tdata = {7'd0, out_reg.frame_status, out_reg.byte_offset, out_reg.payload_byte};
  assign m_tuser = out_reg.item_kind;
  assign m_tlast = out_reg.last;

endmodule

// ===== design/ubx_ff_checker.sv =====
// Port-level checks for the binary frame filter, bound to the top level.
module ubx_ff_checker import ubx_ff_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [31:0]          m_tdata,
  input logic                 m_tuser,
  input logic                 m_tlast
);

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
    else $error("tlast disagrees with item kind");

  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_PAYLOAD) ? (m_tdata[24] == 1'b0) : (m_tdata[7:0] == 8'd0)))
    else $error("unused result field not zero");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid && !m_tready) && !$past(rst) |-> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_ready_after_drain: assert property (@(posedge clk) disable iff (rst)
    !s_tready && m_tready |=> s_tready)
    else $error("input stayed blocked after output drained");

endmodule

bind ubx_frame_filter_top ubx_ff_checker u_ubx_ff_checker (.*);
